[design/triangle_point_query_defines.svh]
// Assertion macros for the triangle point query block.
`ifndef TRIANGLE_POINT_QUERY_DEFINES_SVH
`define TRIANGLE_POINT_QUERY_DEFINES_SVH

// Same-cycle implication, clocked on aclk, disabled during reset.
`define TPQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, disabled during reset.
`define TPQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/tpq_pkg.sv]
`timescale 1ns / 1ps

package tpq_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int PP_W        = 2 * DIFF_W;
    localparam int DOT_W       = 2 * COORD_WIDTH + 3;
    localparam int LO_W        = (DOT_W + 1) / 2;
    localparam int HI_W        = DOT_W - LO_W;
    localparam int PROD_W      = 2 * DOT_W;
    localparam int STAGES      = 7;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]      diff_t;
    typedef logic signed [PP_W-1:0]        pp_t;
    typedef logic signed [DOT_W-1:0]       dot_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic [1:0]                    vidx_t;

    localparam vidx_t VTX_0 = 2'd0;
    localparam vidx_t VTX_1 = 2'd1;
    localparam vidx_t VTX_2 = 2'd2;

    // per-axis products: edge/edge, edge/offset, and squared vertex-to-query deltas
    typedef struct packed {
        pp_t [2:0] e00;
        pp_t [2:0] e01;
        pp_t [2:0] e02;
        pp_t [2:0] e11;
        pp_t [2:0] e12;
        pp_t [8:0] sq;
    } terms_t;

    typedef struct packed {
        dot_t d00;
        dot_t d01;
        dot_t d02;
        dot_t d11;
        dot_t d12;
    } dots_t;

    function automatic dot_t sum3(input pp_t a, input pp_t b, input pp_t c);
        sum3 = DOT_W'(a) + DOT_W'(b) + DOT_W'(c);
    endfunction

endpackage

[design/tpq_diff.sv]
`timescale 1ns / 1ps

module tpq_diff import tpq_pkg::*; (
    input  logic   aclk,
    input  logic   en,
    input  coord_t vtx [3][3],
    input  coord_t qry [3],
    output terms_t terms_o
);

    diff_t  e0_reg [3];
    diff_t  e1_reg [3];
    diff_t  w_reg  [3];
    diff_t  dv_reg [9];
    terms_t terms_reg;

    // stage 1: edge vectors and offsets
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                e0_reg[k] <= DIFF_W'(vtx[2][k]) - DIFF_W'(vtx[0][k]);
                e1_reg[k] <= DIFF_W'(vtx[1][k]) - DIFF_W'(vtx[0][k]);
                w_reg[k]  <= DIFF_W'(qry[k]) - DIFF_W'(vtx[0][k]);
            end
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    dv_reg[3*i+k] <= DIFF_W'(vtx[i][k]) - DIFF_W'(qry[k]);
                end
            end
        end
    end

    // stage 2: per-axis products
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                terms_reg.e00[k] <= e0_reg[k] * e0_reg[k];
                terms_reg.e01[k] <= e0_reg[k] * e1_reg[k];
                terms_reg.e02[k] <= e0_reg[k] * w_reg[k];
                terms_reg.e11[k] <= e1_reg[k] * e1_reg[k];
                terms_reg.e12[k] <= e1_reg[k] * w_reg[k];
            end
            for (int j = 0; j < 9; j++) begin
                terms_reg.sq[j] <= dv_reg[j] * dv_reg[j];
            end
        end
    end

    assign terms_o = terms_reg;

endmodule

[design/tpq_dot.sv]
`timescale 1ns / 1ps

module tpq_dot import tpq_pkg::*; (
    input  logic   aclk,
    input  logic   en,
    input  terms_t terms_i,
    output dots_t  dots_o,
    output vidx_t  near_o
);

    dots_t dots_reg;
    dot_t  dist_reg [3];
    vidx_t best_reg;
    vidx_t best_d_reg;
    vidx_t best_next;
    dot_t  best_dist;

    // stage 3: dot products and squared distances
    always_ff @(posedge aclk) begin
        if (en) begin
            dots_reg.d00 <= sum3(terms_i.e00[0], terms_i.e00[1], terms_i.e00[2]);
            dots_reg.d01 <= sum3(terms_i.e01[0], terms_i.e01[1], terms_i.e01[2]);
            dots_reg.d02 <= sum3(terms_i.e02[0], terms_i.e02[1], terms_i.e02[2]);
            dots_reg.d11 <= sum3(terms_i.e11[0], terms_i.e11[1], terms_i.e11[2]);
            dots_reg.d12 <= sum3(terms_i.e12[0], terms_i.e12[1], terms_i.e12[2]);
            for (int i = 0; i < 3; i++) begin
                dist_reg[i] <= sum3(terms_i.sq[3*i], terms_i.sq[3*i+1], terms_i.sq[3*i+2]);
            end
        end
    end

    // ties keep the lower index
    always_comb begin
        best_next = VTX_0;
        best_dist = dist_reg[0];
        if (dist_reg[1] < best_dist) begin
            best_next = VTX_1;
            best_dist = dist_reg[1];
        end
        if (dist_reg[2] < best_dist) begin
            best_next = VTX_2;
        end
    end

    // stage 4 select, stage 5 align with the wide products
    always_ff @(posedge aclk) begin
        if (en) begin
            best_reg   <= best_next;
            best_d_reg <= best_reg;
        end
    end

    assign dots_o = dots_reg;
    assign near_o = best_d_reg;

endmodule

[design/tpq_wide_mul.sv]
`timescale 1ns / 1ps

module tpq_wide_mul import tpq_pkg::*; (
    input  logic  aclk,
    input  logic  en,
    input  dot_t  a_in,
    input  dot_t  b_in,
    output prod_t prod_o
);

    logic signed [HI_W-1:0]      a_hi;
    logic signed [HI_W-1:0]      b_hi;
    logic [LO_W-1:0]             a_lo;
    logic [LO_W-1:0]             b_lo;
    logic signed [2*HI_W-1:0]    hh_reg;
    logic signed [HI_W+LO_W:0]   hl_reg;
    logic signed [HI_W+LO_W:0]   lh_reg;
    logic [2*LO_W-1:0]           ll_reg;
    prod_t                       prod_reg;

    assign a_hi = a_in[DOT_W-1:LO_W];
    assign b_hi = b_in[DOT_W-1:LO_W];
    assign a_lo = a_in[LO_W-1:0];
    assign b_lo = b_in[LO_W-1:0];

    // signed high half, unsigned low half
    always_ff @(posedge aclk) begin
        if (en) begin
            hh_reg <= a_hi * b_hi;
            hl_reg <= a_hi * $signed({1'b0, b_lo});
            lh_reg <= $signed({1'b0, a_lo}) * b_hi;
            ll_reg <= a_lo * b_lo;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= (PROD_W'(hh_reg) <<< (2 * LO_W))
                      + (PROD_W'(hl_reg) <<< LO_W)
                      + (PROD_W'(lh_reg) <<< LO_W)
                      + PROD_W'(ll_reg);
        end
    end

    assign prod_o = prod_reg;

endmodule

[design/tpq_decide.sv]
`timescale 1ns / 1ps

module tpq_decide import tpq_pkg::*; (
    input  logic  aclk,
    input  logic  en,
    input  prod_t p_d00_d11,
    input  prod_t p_d01_d01,
    input  prod_t p_d11_d02,
    input  prod_t p_d01_d12,
    input  prod_t p_d00_d12,
    input  prod_t p_d01_d02,
    input  vidx_t near_i,
    output logic  inside_o,
    output logic  degen_o,
    output vidx_t near_o
);

    localparam int WIDE_W = PROD_W + 1;
    localparam int SUM_W  = WIDE_W + 2;

    typedef logic signed [WIDE_W-1:0] wide_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    wide_t den_reg;
    wide_t nu_reg;
    wide_t nv_reg;
    vidx_t near6_reg;
    logic  inside_reg;
    logic  degen_reg;
    vidx_t near7_reg;
    sum_t  slack;
    logic  degen_next;
    logic  inside_next;

    // stage 6: denominator and numerators
    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg   <= WIDE_W'(p_d00_d11) - WIDE_W'(p_d01_d01);
            nu_reg    <= WIDE_W'(p_d11_d02) - WIDE_W'(p_d01_d12);
            nv_reg    <= WIDE_W'(p_d00_d12) - WIDE_W'(p_d01_d02);
            near6_reg <= near_i;
        end
    end

    // u + v < 1  <=>  nu + nv - den < 0
    always_comb begin
        slack       = SUM_W'(nu_reg) + SUM_W'(nv_reg) - SUM_W'(den_reg);
        degen_next  = (den_reg == '0);
        inside_next = !degen_next && !nu_reg[WIDE_W-1] && !nv_reg[WIDE_W-1]
                      && slack[SUM_W-1];
    end

    // stage 7: output word
    always_ff @(posedge aclk) begin
        if (en) begin
            inside_reg <= inside_next;
            degen_reg  <= degen_next;
            near7_reg  <= near6_reg;
        end
    end

    assign inside_o = inside_reg;
    assign degen_o  = degen_reg;
    assign near_o   = near7_reg;

endmodule

[design/triangle_point_query.sv]
// Channel   Dir  Handshake           Word
// s_        in   s_valid / s_ready   three vertices and a query point, x/y/z each
// m_        out  m_valid / m_ready   inside_res, nearest_vertex, degenerate
//
// Seven-stage pipeline: one word accepted per cycle while m_ready does not stall the output.
// The depth is set by the six wide products, each split into partial products
// and summed over two stages.
// Reset clears only the per-stage valid bits; payload registers are not reset.
// A stall on m_ready freezes every stage at once and drops s_ready in the same cycle.
`timescale 1ns / 1ps
`include "triangle_point_query_defines.svh"

module triangle_point_query import tpq_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    output logic   s_ready,
    input  coord_t s_vertex0_x,
    input  coord_t s_vertex0_y,
    input  coord_t s_vertex0_z,
    input  coord_t s_vertex1_x,
    input  coord_t s_vertex1_y,
    input  coord_t s_vertex1_z,
    input  coord_t s_vertex2_x,
    input  coord_t s_vertex2_y,
    input  coord_t s_vertex2_z,
    input  coord_t s_query_x,
    input  coord_t s_query_y,
    input  coord_t s_query_z,
    output logic   m_valid,
    input  logic   m_ready,
    output logic   m_inside_res,
    output vidx_t  m_nearest_vertex,
    output logic   m_degenerate
);

    logic [STAGES-1:0] vld_reg;
    logic              en;
    coord_t            vtx [3][3];
    coord_t            qry [3];
    terms_t            terms;
    dots_t             dots;
    vidx_t             near5;
    prod_t             p_d00_d11;
    prod_t             p_d01_d01;
    prod_t             p_d11_d02;
    prod_t             p_d01_d12;
    prod_t             p_d00_d12;
    prod_t             p_d01_d02;

    assign en      = !vld_reg[STAGES-1] || m_ready;
    assign s_ready = en && aresetn;
    assign m_valid = vld_reg[STAGES-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[STAGES-2:0], s_valid};
        end
    end

    assign vtx[0][0] = s_vertex0_x;
    assign vtx[0][1] = s_vertex0_y;
    assign vtx[0][2] = s_vertex0_z;
    assign vtx[1][0] = s_vertex1_x;
    assign vtx[1][1] = s_vertex1_y;
    assign vtx[1][2] = s_vertex1_z;
    assign vtx[2][0] = s_vertex2_x;
    assign vtx[2][1] = s_vertex2_y;
    assign vtx[2][2] = s_vertex2_z;
    assign qry[0]    = s_query_x;
    assign qry[1]    = s_query_y;
    assign qry[2]    = s_query_z;

    tpq_diff u_diff (
        .aclk    (aclk),
        .en      (en),
        .vtx     (vtx),
        .qry     (qry),
        .terms_o (terms)
    );

    tpq_dot u_dot (
        .aclk    (aclk),
        .en      (en),
        .terms_i (terms),
        .dots_o  (dots),
        .near_o  (near5)
    );

    tpq_wide_mul u_mul_d00_d11 (
        .aclk (aclk), .en (en), .a_in (dots.d00), .b_in (dots.d11), .prod_o (p_d00_d11)
    );
    tpq_wide_mul u_mul_d01_d01 (
        .aclk (aclk), .en (en), .a_in (dots.d01), .b_in (dots.d01), .prod_o (p_d01_d01)
    );
    tpq_wide_mul u_mul_d11_d02 (
        .aclk (aclk), .en (en), .a_in (dots.d11), .b_in (dots.d02), .prod_o (p_d11_d02)
    );
    tpq_wide_mul u_mul_d01_d12 (
        .aclk (aclk), .en (en), .a_in (dots.d01), .b_in (dots.d12), .prod_o (p_d01_d12)
    );
    tpq_wide_mul u_mul_d00_d12 (
        .aclk (aclk), .en (en), .a_in (dots.d00), .b_in (dots.d12), .prod_o (p_d00_d12)
    );
    tpq_wide_mul u_mul_d01_d02 (
        .aclk (aclk), .en (en), .a_in (dots.d01), .b_in (dots.d02), .prod_o (p_d01_d02)
    );

    tpq_decide u_decide (
        .aclk      (aclk),
        .en        (en),
        .p_d00_d11 (p_d00_d11),
        .p_d01_d01 (p_d01_d01),
        .p_d11_d02 (p_d11_d02),
        .p_d01_d12 (p_d01_d12),
        .p_d00_d12 (p_d00_d12),
        .p_d01_d02 (p_d01_d02),
        .near_i    (near5),
        .inside_o  (m_inside_res),
        .degen_o   (m_degenerate),
        .near_o    (m_nearest_vertex)
    );

    `TPQ_ASSERT_IMP(a_degen_not_inside, m_valid, !(m_inside_res && m_degenerate), "degenerate flagged inside")
    `TPQ_ASSERT_IMP(a_nearest_range, m_valid, m_nearest_vertex <= VTX_2, "nearest vertex out of range")
    `TPQ_ASSERT_NXT(a_accept_enters, s_valid && s_ready, vld_reg[0], "accepted word not in stage 1")

endmodule

[tb/triangle_point_query_tb.sv]
`timescale 1ns / 1ps

module triangle_point_query_tb import tpq_pkg::*;;

    localparam int NUM_RANDOM  = 850;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AFTER  = 150;

    // {v0 xyz, v1 xyz, v2 xyz, q xyz}, vertex0_x in the top slot
    typedef coord_t [11:0] tri_word_t;

    typedef struct packed {
        logic  in_tri;
        vidx_t nearest;
        logic  degen;
    } tri_result_t;

    typedef enum {RX_FREE, RX_COIN, RX_MOSTLY, RX_SPARSE} rx_mode_t;
    typedef enum {GEN_RAW, GEN_PLANAR, GEN_EDGE, GEN_FLAT, GEN_TIE, GEN_CORNER} gen_kind_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    tri_word_t   s_word = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_inside_res;
    vidx_t       m_nearest_vertex;
    logic        m_degenerate;

    tri_word_t   pending_q[$];
    tri_result_t expected_q[$];
    tri_result_t want;

    int          burst_left = 0;
    int          gap_left = 0;
    int          hold_cnt = 0;
    logic        hold_done = 1'b0;
    int          mode_left = 0;
    rx_mode_t    rx_mode = RX_FREE;
    int          results_seen = 0;
    int          fail_cnt = 0;
    int          cycle_cnt = 0;

    triangle_point_query dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_vertex0_x      (s_word[11]),
        .s_vertex0_y      (s_word[10]),
        .s_vertex0_z      (s_word[9]),
        .s_vertex1_x      (s_word[8]),
        .s_vertex1_y      (s_word[7]),
        .s_vertex1_z      (s_word[6]),
        .s_vertex2_x      (s_word[5]),
        .s_vertex2_y      (s_word[4]),
        .s_vertex2_z      (s_word[3]),
        .s_query_x        (s_word[2]),
        .s_query_y        (s_word[1]),
        .s_query_z        (s_word[0]),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_inside_res     (m_inside_res),
        .m_nearest_vertex (m_nearest_vertex),
        .m_degenerate     (m_degenerate)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Exact barycentric test without a divide, plus nearest vertex by squared distance.
    function automatic tri_result_t predict_query(input tri_word_t w);
        longint vtx[3][3];
        longint qp[3];
        longint e0[3], e1[3], off[3], sqd[3];
        longint d00, d01, d02, d11, d12, best;
        logic signed [127:0] w00, w01, w02, w11, w12, den, nu, nv;
        tri_result_t r;
        int i, k;
        for (i = 0; i < 3; i++) begin
            for (k = 0; k < 3; k++)
                vtx[i][k] = longint'(signed'(w[11 - 3*i - k]));
        end
        for (k = 0; k < 3; k++)
            qp[k] = longint'(signed'(w[2 - k]));
        d00 = 0; d01 = 0; d02 = 0; d11 = 0; d12 = 0;
        for (k = 0; k < 3; k++) begin
            e0[k] = vtx[2][k] - vtx[0][k];
            e1[k] = vtx[1][k] - vtx[0][k];
            off[k] = qp[k] - vtx[0][k];
            d00 += e0[k] * e0[k];
            d01 += e0[k] * e1[k];
            d02 += e0[k] * off[k];
            d11 += e1[k] * e1[k];
            d12 += e1[k] * off[k];
        end
        w00 = d00; w01 = d01; w02 = d02; w11 = d11; w12 = d12;
        den = w00 * w11 - w01 * w01;
        nu  = w11 * w02 - w01 * w12;
        nv  = w00 * w12 - w01 * w02;
        r.degen  = (den == 0);
        r.in_tri = !r.degen && (nu >= 0) && (nv >= 0) && (nu + nv < den);
        for (i = 0; i < 3; i++) begin
            sqd[i] = 0;
            for (k = 0; k < 3; k++)
                sqd[i] += (vtx[i][k] - qp[k]) * (vtx[i][k] - qp[k]);
        end
        r.nearest = VTX_0;
        best = sqd[0];
        if (sqd[1] < best) begin
            r.nearest = VTX_1;
            best = sqd[1];
        end
        if (sqd[2] < best)
            r.nearest = VTX_2;
        return r;
    endfunction

    function automatic tri_word_t pts(input int ax, ay, az, bx, by, bz,
                                      input int cx, cy, cz, qx, qy, qz);
        return {coord_t'(ax), coord_t'(ay), coord_t'(az), coord_t'(bx), coord_t'(by),
                coord_t'(bz), coord_t'(cx), coord_t'(cy), coord_t'(cz), coord_t'(qx),
                coord_t'(qy), coord_t'(qz)};
    endfunction

    function automatic int rnd_in(input int r);
        return int'($urandom_range(0, 2 * r)) - r;
    endfunction

    function automatic int corner_val();
        case ($urandom_range(0, 5))
            0: return -32768;
            1: return 32767;
            2: return -1;
            3: return 0;
            4: return 1;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    task automatic add_directed();
        pending_q.push_back(pts(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_q.push_back(pts(-32768, -32768, -32768, -32768, -32768, -32768,
                                -32768, -32768, -32768, -32768, -32768, -32768));
        pending_q.push_back(pts(32767, 32767, 32767, 32767, 32767, 32767,
                                32767, 32767, 32767, 32767, 32767, 32767));
        pending_q.push_back(pts(-32768, -32768, 0, 32767, -32768, 0, -32768, 32767, 0, 0, 0, 0));
        pending_q.push_back(pts(-32768, -32768, -32768, 32767, -32768, 32767,
                                -32768, 32767, 32767, -100, -100, 32767));
        pending_q.push_back(pts(-32768, 32767, -32768, 32767, -32768, 32767,
                                32767, 32767, -32768, -32768, -32768, 32767));
        // right triangle in z=0: interior, off-plane, outside, corners and edges
        pending_q.push_back(pts(0, 0, 0, 100, 0, 0, 0, 100, 0, 20, 20, 0));
        pending_q.push_back(pts(0, 0, 0, 100, 0, 0, 0, 100, 0, 20, 20, 50));
        pending_q.push_back(pts(0, 0, 0, 100, 0, 0, 0, 100, 0, -1, 20, 0));
        pending_q.push_back(pts(0, 0, 0, 100, 0, 0, 0, 100, 0, 0, 0, 0));
        pending_q.push_back(pts(0, 0, 0, 100, 0, 0, 0, 100, 0, 50, 50, 0));
        pending_q.push_back(pts(0, 0, 0, 100, 0, 0, 0, 100, 0, 0, 50, 0));
        pending_q.push_back(pts(0, 0, 0, 100, 0, 0, 0, 100, 0, 100, 0, 0));
        pending_q.push_back(pts(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 0));
        // degenerate: collinear, coincident
        pending_q.push_back(pts(0, 0, 0, 10, 10, 10, 20, 20, 20, 5, 5, 5));
        pending_q.push_back(pts(7, 7, 7, 7, 7, 7, 1, 2, 3, 7, 7, 6));
        // distance ties
        pending_q.push_back(pts(-10, 0, 0, 10, 0, 0, 0, 50, 0, 0, 5, 0));
        pending_q.push_back(pts(0, 100, 0, -10, 0, 0, 10, 0, 0, 0, 0, 0));
        pending_q.push_back(pts(10, 0, 0, 0, 100, 0, -10, 0, 0, 0, 0, 0));
        pending_q.push_back(pts(3, 4, 0, -3, 4, 0, 5, 0, 0, 0, 0, 0));
        pending_q.push_back(pts(0, 0, 0, 100, 0, 0, 0, 100, 0, 5, 90, 0));
        pending_q.push_back(pts(-5, 3, 1, 2, -4, 0, 6, 6, -2, 32767, -32768, 32767));
    endtask

    task automatic add_random();
        int v[12];
        int p[3];
        int n, i, k, pick, rad, a, b, s1, s2, tie;
        gen_kind_t kind;
        tri_word_t w;
        for (n = 0; n < NUM_RANDOM; n++) begin
            pick = $urandom_range(0, 9);
            kind = pick < 2 ? GEN_RAW : pick < 5 ? GEN_PLANAR : pick < 6 ? GEN_EDGE :
                   pick < 7 ? GEN_FLAT : pick < 8 ? GEN_TIE : GEN_CORNER;
            case ($urandom_range(0, 3))
                0: rad = 15;
                1: rad = 255;
                2: rad = 4095;
                default: rad = 16383;
            endcase
            case (kind)
                GEN_RAW: begin
                    for (i = 0; i < 12; i++)
                        v[i] = int'($urandom_range(0, 65535)) - 32768;
                end
                GEN_PLANAR, GEN_EDGE: begin
                    if (kind == GEN_EDGE) begin
                        // multiples of 256 so the boundary points land exactly
                        for (i = 0; i < 9; i++)
                            v[i] = 256 * rnd_in(63);
                        a = $urandom_range(0, 256);
                        case ($urandom_range(0, 2))
                            0: b = 256 - a;
                            1: b = 0;
                            default: begin
                                b = a;
                                a = 0;
                            end
                        endcase
                    end else begin
                        for (i = 0; i < 9; i++)
                            v[i] = rnd_in(rad);
                        a = int'($urandom_range(0, 300)) - 20;
                        b = int'($urandom_range(0, 300)) - 20;
                    end
                    for (k = 0; k < 3; k++) begin
                        v[9 + k] = v[k] + (a * (v[3 + k] - v[k]) + b * (v[6 + k] - v[k])) / 256;
                        if (kind == GEN_PLANAR && $urandom_range(0, 1) == 0)
                            v[9 + k] += rnd_in(3);
                    end
                end
                GEN_FLAT: begin
                    s1 = rnd_in(2);
                    s2 = rnd_in(2);
                    for (k = 0; k < 3; k++) begin
                        v[k] = rnd_in(8000);
                        p[k] = rnd_in(rad < 2000 ? rad : 2000);
                        v[3 + k] = v[k] + s1 * p[k];
                        v[6 + k] = v[k] + s2 * p[k];
                        v[9 + k] = rnd_in(16000);
                    end
                end
                GEN_TIE: begin
                    for (k = 0; k < 3; k++) begin
                        v[9 + k] = rnd_in(8000);
                        p[k] = rnd_in(rad < 8000 ? rad : 8000);
                        v[k] = rnd_in(16000);
                        v[3 + k] = rnd_in(16000);
                        v[6 + k] = rnd_in(16000);
                    end
                    tie = $urandom_range(0, 3);
                    // rotated and negated offsets have the same length
                    for (k = 0; k < 3; k++) begin
                        if (tie != 1)
                            v[k] = v[9 + k] + p[k];
                        if (tie != 2)
                            v[3 + k] = v[9 + k] + (tie == 1 ? p[k] : p[(k + 1) % 3]);
                        if (tie == 1 || tie == 2)
                            v[6 + k] = v[9 + k] + p[(k + 1) % 3];
                        if (tie == 3)
                            v[6 + k] = v[9 + k] - p[k];
                    end
                end
                default: begin
                    for (i = 0; i < 12; i++)
                        v[i] = corner_val();
                end
            endcase
            for (i = 0; i < 12; i++)
                w[11 - i] = coord_t'(v[i]);
            pending_q.push_back(w);
        end
    endtask

    // sender: bursts of random length separated by random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                expected_q.push_back(predict_query(s_word));
            if (!s_valid || s_ready) begin
                if (gap_left > 0 || pending_q.size() == 0) begin
                    s_valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left <= gap_left - 1;
                end else begin
                    s_valid <= 1'b1;
                    s_word <= pending_q.pop_front();
                    if (burst_left > 0) begin
                        burst_left <= burst_left - 1;
                    end else begin
                        burst_left <= $urandom_range(0, 40);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
        end
    end

    // receiver: one long hold-off, otherwise stall modes that are re-picked when a random countdown runs out
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            hold_cnt <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                mode_left <= $urandom_range(16, 96);
                rx_mode <= rx_mode_t'($urandom_range(0, 3));
            end else begin
                mode_left <= mode_left - 1;
            end
            case (rx_mode)
                RX_FREE:   m_ready <= 1'b1;
                RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                RX_MOSTLY: m_ready <= ($urandom_range(0, 9) != 0);
                default:   m_ready <= (mode_left % 4 == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            if (expected_q.size() == 0) begin
                $error("result word with nothing expected");
                fail_cnt = fail_cnt + 1;
            end else begin
                want = expected_q.pop_front();
                if (m_inside_res !== want.in_tri) begin
                    $error("inside_res expected %0d got %0d", want.in_tri, m_inside_res);
                    fail_cnt = fail_cnt + 1;
                end
                if (m_nearest_vertex !== want.nearest) begin
                    $error("nearest_vertex expected %0d got %0d", want.nearest, m_nearest_vertex);
                    fail_cnt = fail_cnt + 1;
                end
                if (m_degenerate !== want.degen) begin
                    $error("degenerate expected %0d got %0d", want.degen, m_degenerate);
                    fail_cnt = fail_cnt + 1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("[triangle_point_query] ERROR");
            $finish;
        end
    end

    initial begin
        add_directed();
        add_random();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        while (pending_q.size() != 0 || s_valid)
            @(posedge aclk);
        while (expected_q.size() != 0)
            @(posedge aclk);
        repeat (4 * STAGES) @(posedge aclk);
        if (fail_cnt == 0) begin
            $display("[triangle_point_query] OK");
        end else begin
            $display("[triangle_point_query] ERROR");
        end
        $finish;
    end

endmodule
